[hw/rtl/srr_pkg.sv]
// ----------------------------------------------------------------------------
// srr_pkg
// Shared constants, controller/datapath handshake structs and checksum helpers
// for the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

   localparam int DEF_WINDOW       = 8;
   localparam int DEF_PACKET_BYTES = 128;

   localparam int SEQ_W   = 24;
   localparam int CSUM_W  = 32;
   localparam int WORD_W  = 64;
   localparam int COUNT_W = 4;
   localparam int LEN_W   = 8;

   localparam logic CMD_WORD  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef struct packed {
      logic take_word;
      logic take_drain;
      logic finish;
      logic scan_clear;
      logic scan_end;
      logic load_ack;
      logic load_drain;
   } srr_cmd_type;

   typedef struct packed {
      logic pending;
      logic last_word;
      logic pkt_good;
      logic seq_next;
      logic scan_hit;
      logic out_free;
   } srr_status_type;

   function automatic logic [CSUM_W-1:0] srr_finish_sum(input logic [31:0] s);
      logic [16:0] a;
      logic [15:0] f;
      logic [15:0] c;
      a = 17'(s[15:0]) + 17'(s[31:16]);
      f = a[15:0] + 16'(a[16]);
      c = 16'hffff - f;
      return {{16{c[15]}}, c};
   endfunction

   function automatic logic [CSUM_W-1:0] srr_ack_csum(input logic [SEQ_W-1:0] ack);
      logic [31:0] s;
      s = 32'({ack[15:8], ack[23:16]}) + 32'(ack[7:0]);
      return srr_finish_sum(s);
   endfunction

endpackage

[hw/rtl/srr_req_if.sv]
// ----------------------------------------------------------------------------
// srr_req_if
// Request channel: packet words and drain commands.
// ----------------------------------------------------------------------------
interface srr_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [63:0] word_data;

   modport source (output valid, output command, output word_data, input ready);
   modport sink   (input valid, input command, input word_data, output ready);
endinterface

[hw/rtl/srr_rsp_if.sv]
// ----------------------------------------------------------------------------
// srr_rsp_if
// Response channel: acknowledgements and delivered payload words.
// ----------------------------------------------------------------------------
interface srr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [23:0] ack_number;
   logic [31:0] ack_checksum;
   logic [63:0] payload_word;
   logic [3:0]  byte_count;
   logic        end_of_message;

   modport source (output valid, output kind, output ack_number, output ack_checksum,
                   output payload_word, output byte_count, output end_of_message,
                   input ready);
   modport sink   (input valid, input kind, input ack_number, input ack_checksum,
                   input payload_word, input byte_count, input end_of_message,
                   output ready);
endinterface

[hw/rtl/selective_repeat_receiver_top.sv]
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top
// Selective repeat receiver with reorder window and drain-based delivery.
// ----------------------------------------------------------------------------
// req_bus carries packet words (command 0) and drain commands (command 1);
// rsp_bus returns acknowledgements and delivered payload words.
// Packet words are taken one per cycle while the sequencer is idle. After the
// last word of a packet the sequencer checks length and checksum in its
// finish state, then for an in-order packet walks the reorder slots and
// clears each released one, then loads the ack of a good packet once the
// response register is free.
// A drain command reads the slot memory into a read register, and its word
// is loaded into the response register once that is free; no new item is
// taken until then. Packet words that arrive while a delivery is pending,
// and drains with nothing pending, are taken and dropped without a response.
// Reset clears the window, the slot valid bits, the word position and the
// drain counters; no memory clearing pass is needed. When rsp_bus stalls, the
// response register holds its item and the sequencer waits to load the next.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_top #(
   parameter int WINDOW       = srr_pkg::DEF_WINDOW,
   parameter int PACKET_BYTES = srr_pkg::DEF_PACKET_BYTES
) (
   input logic         clock,
   input logic         reset,
   srr_req_if.sink     req_bus,
   srr_rsp_if.source   rsp_bus
);
   import srr_pkg::*;

   srr_cmd_type    cmd;
   srr_status_type status;

   srr_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   srr_datapath #(
      .WINDOW       (WINDOW),
      .PACKET_BYTES (PACKET_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .word_data          (req_bus.word_data),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_kind           (rsp_bus.kind),
      .rsp_ack_number     (rsp_bus.ack_number),
      .rsp_ack_checksum   (rsp_bus.ack_checksum),
      .rsp_payload_word   (rsp_bus.payload_word),
      .rsp_byte_count     (rsp_bus.byte_count),
      .rsp_end_of_message (rsp_bus.end_of_message)
   );

endmodule

[hw/rtl/srr_datapath.sv]
// ----------------------------------------------------------------------------
// srr_datapath
// Checksum accumulation, reorder slot storage, window state, drain counters
// and the response register.
// ----------------------------------------------------------------------------
module srr_datapath #(
   parameter int WINDOW       = srr_pkg::DEF_WINDOW,
   parameter int PACKET_BYTES = srr_pkg::DEF_PACKET_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srr_pkg::srr_cmd_type    cmd,
   output srr_pkg::srr_status_type status,
   input  logic [63:0]            word_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [23:0]            rsp_ack_number,
   output logic [31:0]            rsp_ack_checksum,
   output logic [63:0]            rsp_payload_word,
   output logic [3:0]             rsp_byte_count,
   output logic                   rsp_end_of_message
);
   import srr_pkg::*;

   localparam int PKT_WORDS  = (PACKET_BYTES + 7) / 8;
   localparam int SLOT_WORDS = PKT_WORDS - 1;
   localparam int ROOM       = PACKET_BYTES - 8;
   localparam int IDX_W      = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int POS_W      = $clog2(PKT_WORDS);
   localparam int DW_W       = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
   localparam int MEM_DEPTH  = WINDOW * SLOT_WORDS;
   localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W:0] b);
      logic [IDX_W:0] s;
      s = (IDX_W+1)'(a) + b;
      if (s >= (IDX_W+1)'(WINDOW)) begin
         s = s - (IDX_W+1)'(WINDOW);
      end
      return s[IDX_W-1:0];
   endfunction

   logic [SEQ_W-1:0]  m_ff, m_in;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [31:0]       acc_ff, acc_in;
   logic [31:0]       stored_ff, stored_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              wr_ok_ff, wr_ok_in;
   logic              next_ff, next_in;
   logic              pending_ff, pending_in;
   logic [IDX_W-1:0]  drain_slot_ff, drain_slot_in;
   logic [DW_W-1:0]   drain_word_ff, drain_word_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              out_valid_ff, out_valid_in;
   logic              kind_ff, kind_in;
   logic [SEQ_W-1:0]  ackn_ff, ackn_in;
   logic [CSUM_W-1:0] ackc_ff, ackc_in;
   logic [WORD_W-1:0] pay_ff, pay_in;
   logic [COUNT_W-1:0] bc_ff, bc_in;
   logic              eom_ff, eom_in;

   logic [WORD_W-1:0] pay_mem [MEM_DEPTH];
   logic [LEN_W-1:0]  len_mem [WINDOW];
   logic [WORD_W-1:0] rd_data_ff;
   logic [LEN_W-1:0]  rd_len_ff;

   logic [SEQ_W-1:0]  hd_seq;
   logic [SEQ_W:0]    hd_d;
   logic              hd_win;
   logic [IDX_W-1:0]  hd_slot;
   logic [31:0]       word_sum;
   logic [9:0]        bpos;
   logic [15:0]       lane16;
   logic              pkt_good;
   logic              out_free;
   logic              pay_we;
   logic              len_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [8:0]        d_off;
   logic [8:0]        d_len;
   logic [8:0]        d_rem;
   logic [COUNT_W-1:0] d_cnt;
   logic [5:0]        d_words;
   logic              d_last;
   logic [CNT_W-1:0]  d_remain;
   logic [WORD_W-1:0] d_mask;

   assign out_free = !out_valid_ff || rsp_ready;
   assign pkt_good = (len_ff <= LEN_W'(ROOM)) && (srr_finish_sum(acc_ff) == stored_ff);

   assign hd_seq  = {word_data[39:32], word_data[47:40], word_data[55:48]};
   assign hd_d    = {1'b0, hd_seq} - {1'b0, m_ff} - (SEQ_W+1)'(1);
   assign hd_win  = hd_d < (SEQ_W+1)'(WINDOW);
   assign hd_slot = wrap_add(base_ff, hd_d[IDX_W:0]);

   always_comb begin
      word_sum = 32'd0;
      for (int j = 0; j < 4; j++) begin
         bpos   = 10'(pos_ff) * 10'd8 + 10'(2 * j);
         lane16 = word_data[16*j +: 16];
         if (bpos + 10'd1 >= 10'(PACKET_BYTES)) begin
            lane16[15:8] = 8'd0;
         end
         if (bpos >= 10'd4 && bpos < 10'(PACKET_BYTES)) begin
            word_sum = word_sum + 32'(lane16);
         end
      end
   end

   assign pay_we  = cmd.take_word && (pos_ff != '0) && wr_ok_ff;
   assign len_we  = cmd.finish && pkt_good && wr_ok_ff;
   assign wr_addr = ADDR_W'(slot_ff) * ADDR_W'(SLOT_WORDS) + ADDR_W'(pos_ff - POS_W'(1));
   assign rd_addr = ADDR_W'(drain_slot_ff) * ADDR_W'(SLOT_WORDS) + ADDR_W'(drain_word_ff);

   always_comb begin
      d_off    = 9'(drain_word_ff) * 9'd8;
      d_len    = 9'(rd_len_ff);
      d_rem    = (d_len > d_off) ? d_len - d_off : 9'd0;
      d_cnt    = (d_rem > 9'd8) ? 4'd8 : d_rem[3:0];
      d_words  = (rd_len_ff == '0) ? 6'd1 : 6'((9'(rd_len_ff) + 9'd7) >> 3);
      d_last   = (6'(drain_word_ff) + 6'd1) >= d_words;
      d_remain = (remain_ff != '0) ? remain_ff - CNT_W'(1) : '0;
      for (int k = 0; k < 8; k++) begin
         d_mask[8*k +: 8] = (4'(k) < d_cnt) ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      m_in          = m_ff;
      base_in       = base_ff;
      valid_in      = valid_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      stored_in     = stored_ff;
      len_in        = len_ff;
      slot_in       = slot_ff;
      wr_ok_in      = wr_ok_ff;
      next_in       = next_ff;
      pending_in    = pending_ff;
      drain_slot_in = drain_slot_ff;
      drain_word_in = drain_word_ff;
      remain_in     = remain_ff;
      scan_idx_in   = scan_idx_ff;
      scan_cnt_in   = scan_cnt_ff;
      out_valid_in  = out_valid_ff;
      kind_in       = kind_ff;
      ackn_in       = ackn_ff;
      ackc_in       = ackc_ff;
      pay_in        = pay_ff;
      bc_in         = bc_ff;
      eom_in        = eom_ff;

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.take_word) begin
         acc_in = acc_ff + word_sum;
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff == '0) begin
            stored_in = word_data[31:0];
            len_in    = word_data[63:56];
            slot_in   = hd_slot;
            wr_ok_in  = hd_win && !valid_ff[hd_slot];
            next_in   = (hd_d == '0);
         end
      end

      if (cmd.finish) begin
         pos_in      = '0;
         acc_in      = '0;
         scan_idx_in = base_ff;
         scan_cnt_in = '0;
         if (pkt_good && wr_ok_ff) begin
            valid_in[slot_ff] = 1'b1;
         end
      end

      if (cmd.scan_clear) begin
         valid_in[scan_idx_ff] = 1'b0;
         scan_idx_in = wrap_add(scan_idx_ff, (IDX_W+1)'(1));
         scan_cnt_in = scan_cnt_ff + CNT_W'(1);
      end

      if (cmd.scan_end) begin
         m_in          = m_ff + SEQ_W'(scan_cnt_ff);
         base_in       = scan_idx_ff;
         pending_in    = 1'b1;
         drain_slot_in = base_ff;
         drain_word_in = '0;
         remain_in     = scan_cnt_ff;
      end

      if (cmd.load_ack) begin
         out_valid_in = 1'b1;
         kind_in      = KIND_ACK;
         ackn_in      = m_ff;
         ackc_in      = srr_ack_csum(m_ff);
         pay_in       = '0;
         bc_in        = '0;
         eom_in       = 1'b0;
      end

      if (cmd.load_drain) begin
         out_valid_in = 1'b1;
         kind_in      = KIND_PAYLOAD;
         ackn_in      = '0;
         ackc_in      = '0;
         pay_in       = rd_data_ff & d_mask;
         bc_in        = d_cnt;
         eom_in       = 1'b0;
         if (d_last) begin
            drain_word_in = '0;
            drain_slot_in = wrap_add(drain_slot_ff, (IDX_W+1)'(1));
            remain_in     = d_remain;
            if (d_remain == '0) begin
               pending_in = 1'b0;
               eom_in     = 1'b1;
            end
         end else begin
            drain_word_in = drain_word_ff + DW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff          <= '0;
         base_ff       <= '0;
         valid_ff      <= '0;
         pos_ff        <= '0;
         acc_ff        <= '0;
         pending_ff    <= 1'b0;
         drain_slot_ff <= '0;
         drain_word_ff <= '0;
         remain_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         m_ff          <= m_in;
         base_ff       <= base_in;
         valid_ff      <= valid_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         pending_ff    <= pending_in;
         drain_slot_ff <= drain_slot_in;
         drain_word_ff <= drain_word_in;
         remain_ff     <= remain_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stored_ff   <= stored_in;
      len_ff      <= len_in;
      slot_ff     <= slot_in;
      wr_ok_ff    <= wr_ok_in;
      next_ff     <= next_in;
      scan_idx_ff <= scan_idx_in;
      scan_cnt_ff <= scan_cnt_in;
      kind_ff     <= kind_in;
      ackn_ff     <= ackn_in;
      ackc_ff     <= ackc_in;
      pay_ff      <= pay_in;
      bc_ff       <= bc_in;
      eom_ff      <= eom_in;
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[wr_addr] <= word_data;
      end
      if (cmd.take_drain) begin
         rd_data_ff <= pay_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[slot_ff] <= len_ff;
      end
      if (cmd.take_drain) begin
         rd_len_ff <= len_mem[drain_slot_ff];
      end
   end

   assign status.pending   = pending_ff;
   assign status.last_word = (pos_ff == POS_W'(PKT_WORDS - 1));
   assign status.pkt_good  = pkt_good;
   assign status.seq_next  = next_ff;
   assign status.scan_hit  = (scan_cnt_ff < CNT_W'(WINDOW)) && valid_ff[scan_idx_ff];
   assign status.out_free  = out_free;

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_ack_number     = ackn_ff;
   assign rsp_ack_checksum   = ackc_ff;
   assign rsp_payload_word   = pay_ff;
   assign rsp_byte_count     = bc_ff;
   assign rsp_end_of_message = eom_ff;

endmodule

[hw/rtl/srr_controller.sv]
// ----------------------------------------------------------------------------
// srr_controller
// Sequencer for word intake, packet finish, release scan and response loads.
// ----------------------------------------------------------------------------
module srr_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   input  srr_pkg::srr_status_type status,
   output srr_pkg::srr_cmd_type    cmd
);
   import srr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FINISH = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_ACK    = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_DRAIN) begin
                  if (status.pending) begin
                     cmd.take_drain = 1'b1;
                     state_in       = ST_DRAIN;
                  end
               end else if (!status.pending) begin
                  cmd.take_word = 1'b1;
                  if (status.last_word) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (!status.pkt_good) begin
               state_in = ST_IDLE;
            end else if (status.seq_next) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_SCAN: begin
            if (status.scan_hit) begin
               cmd.scan_clear = 1'b1;
            end else begin
               cmd.scan_end = 1'b1;
               state_in     = ST_ACK;
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.load_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.load_drain = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[tb/tb_if.sv]
// ----------------------------------------------------------------------------
// tb_if
// Interface files are provided by the RTL; this file carries shared testbench
// types for the receiver bench.
// ----------------------------------------------------------------------------
package tb_srr_pkg;
   import srr_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [23:0] ack_number;
      logic [31:0] ack_checksum;
      logic [63:0] payload_word;
      logic [3:0]  byte_count;
      logic        end_of_message;
   } rsp_item_type;
endpackage

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective repeat receiver. Builds packets with
// valid and corrupted checksums, in-order, reordered, duplicate and stale
// sequence numbers, drains released payloads, and compares every response
// item against a behavioral predictor of the window and drain logic.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srr_pkg::*;
   import tb_srr_pkg::*;

   localparam int WIN   = DEF_WINDOW;
   localparam int PB    = DEF_PACKET_BYTES;
   localparam int PW    = (PB + 7) / 8;
   localparam int SW    = PW - 1;
   localparam int ROOM  = PB - 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   srr_req_if req_bus ();
   srr_rsp_if rsp_bus ();

   selective_repeat_receiver_top u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [23:0] in_order_seq;
   logic        slot_ok [WIN];
   logic [63:0] slot_data [WIN*SW];
   logic [7:0]  slot_len [WIN];
   logic [63:0] stage [PW];
   int          word_pos;
   logic [31:0] sum_acc;
   logic        pending;
   int          drain_slot, drain_word, runs_left;

   rsp_item_type expected_rsps [$];
   int errors = 0, n_acks = 0, n_words = 0, n_items = 0;

   function automatic logic [31:0] fold_csum(input logic [31:0] s);
      logic [31:0] c;
      while (s[31:16] != 0) s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
      c = 32'hffff - s;
      if (c[15]) c[31:16] = 16'hffff;
      return c;
   endfunction

   function automatic logic [7:0] stage_byte(input int b);
      return (b >= PB) ? 8'h0 : stage[b/8][(b%8)*8 +: 8];
   endfunction

   function automatic rsp_item_type ack_of(input logic [23:0] a);
      rsp_item_type r;
      r.kind = KIND_ACK; r.ack_number = a;
      r.ack_checksum = fold_csum({16'h0, a[15:8], a[23:16]} + {24'h0, a[7:0]});
      r.payload_word = '0; r.byte_count = '0; r.end_of_message = 1'b0;
      return r;
   endfunction

   task automatic predictor_reset();
      in_order_seq = '0; word_pos = 0; sum_acc = '0; pending = 1'b0;
      drain_slot = 0; drain_word = 0; runs_left = 0;
      for (int i = 0; i < WIN; i++) slot_ok[i] = 1'b0;
   endtask

   function automatic void fill_slot(input int idx, input logic [7:0] len);
      if (slot_ok[idx]) return;
      for (int k = 0; k < SW; k++) slot_data[idx*SW + k] = stage[k+1];
      slot_len[idx] = len; slot_ok[idx] = 1'b1;
   endfunction

   // returns 1 when the item produces a response
   function automatic bit predict_receiver(input logic cmd, input logic [63:0] data,
                                           output rsp_item_type r);
      int slot, len, nw, off, cnt, idx;
      logic [63:0] w;
      logic [31:0] seq, stored, m, n;
      int run;
      r = ack_of(24'd0);
      if (cmd == CMD_DRAIN) begin
         if (!pending) return 0;
         slot = drain_slot % WIN; len = slot_len[slot];
         nw = len ? (len + 7) / 8 : 1; off = drain_word * 8;
         cnt = len > off ? len - off : 0;
         if (cnt > 8) cnt = 8;
         idx = drain_word < SW ? drain_word : SW - 1;
         w = slot_data[slot*SW + idx];
         if (cnt < 8) w &= (64'h1 << (8*cnt)) - 64'h1;
         r.kind = KIND_PAYLOAD; r.ack_number = '0; r.ack_checksum = '0;
         r.payload_word = w; r.byte_count = 4'(cnt); r.end_of_message = 1'b0;
         drain_word++;
         if (drain_word >= nw) begin
            drain_word = 0; drain_slot = (slot + 1) % WIN;
            if (runs_left > 0) runs_left--;
            if (runs_left == 0) begin
               pending = 1'b0; r.end_of_message = 1'b1;
            end
         end
         return 1;
      end
      if (pending) return 0;
      stage[word_pos] = data;
      for (int j = 0; j < 4; j++) begin
         int b;
         b = word_pos*8 + 2*j;
         if (b >= 4 && b < PB) sum_acc += {stage_byte(b+1), stage_byte(b)};
      end
      word_pos++;
      if (word_pos < PW) return 0;
      word_pos = 0;
      seq = {stage_byte(4), stage_byte(5), stage_byte(6)};
      len = stage_byte(7);
      stored = {stage_byte(3), stage_byte(2), stage_byte(1), stage_byte(0)};
      m = in_order_seq;
      w = {32'h0, fold_csum(sum_acc)};
      sum_acc = '0;
      if (len > ROOM || w[31:0] != stored) return 0;
      if (seq > m + 1 && seq <= m + WIN) begin
         fill_slot((seq - 1) % WIN, 8'(len));
         r = ack_of(m[23:0]);
      end else if (seq == m + 1) begin
         fill_slot(m % WIN, 8'(len));
         n = m; run = 0;
         while (run < WIN && slot_ok[n % WIN]) begin
            slot_ok[n % WIN] = 1'b0; n++; run++;
         end
         in_order_seq = n[23:0]; pending = 1'b1;
         drain_slot = m % WIN; drain_word = 0; runs_left = run;
         r = ack_of(in_order_seq);
      end else r = ack_of(m[23:0]);
      return 1;
   endfunction

   // ---------------- driving
   task automatic send_item(input logic cmd, input logic [63:0] data, input bit use_fixed,
                            input rsp_item_type fixed, input bit fixed_has);
      rsp_item_type r;
      bit has;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      has = predict_receiver(cmd, data, r);
      if (use_fixed && (has != fixed_has || (has && r != fixed))) begin
         $display("%0t directed row mismatch exp has=%0b k=%0b a=%h w=%h", $time,
                  fixed_has, fixed.kind, fixed.ack_number, fixed.payload_word);
         $display("%0t                       act has=%0b k=%0b a=%h w=%h", $time,
                  has, r.kind, r.ack_number, r.payload_word);
         errors++;
      end
      if (has) expected_rsps.push_back(r);
      req_bus.valid <= 1'b1; req_bus.command <= cmd; req_bus.word_data <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n_items++;
      @(negedge clock);
   endtask

   // hold the request side idle until every expected item has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // build a packet image with correct or broken checksum and send its words
   task automatic send_packet(input logic [23:0] seq, input logic [7:0] len, input bit bad);
      logic [63:0] p [PW];
      logic [31:0] s;
      for (int i = 0; i < PW; i++) p[i] = rand64();
      p[0][63:32] = {len, seq[7:0], seq[15:8], seq[23:16]};
      s = '0;
      for (int b = 4; b < PB; b += 2) s += {p[(b+1)/8][((b+1)%8)*8 +: 8], p[b/8][(b%8)*8 +: 8]};
      p[0][31:0] = fold_csum(s) ^ (bad ? 32'h1 << $urandom_range(0, 31) : 32'h0);
      for (int i = 0; i < PW; i++) send_item(CMD_WORD, p[i], 0, ack_of(24'd0), 0);
   endtask

   task automatic drain_all();
      while (pending) send_item(CMD_DRAIN, rand64(), 0, ack_of(24'd0), 0);
   endtask

   // ---------------- checking
   int rsp_wait;
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else if (rsp_wait > 0) begin
         rsp_bus.ready <= 1'b0; rsp_wait--;
      end else rsp_bus.ready <= 1'b1;
   end

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response kind=%0b", $time, rsp_bus.kind);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_bus.kind == KIND_ACK) n_acks++; else n_words++;
            if (rsp_bus.kind !== e.kind || rsp_bus.ack_number !== e.ack_number ||
                rsp_bus.ack_checksum !== e.ack_checksum ||
                rsp_bus.payload_word !== e.payload_word ||
                rsp_bus.byte_count !== e.byte_count ||
                rsp_bus.end_of_message !== e.end_of_message) begin
               $display("%0t mismatch exp k=%0b a=%h c=%h w=%h n=%0d e=%0b", $time, e.kind,
                        e.ack_number, e.ack_checksum, e.payload_word, e.byte_count,
                        e.end_of_message);
               $display("%0t          act k=%0b a=%h c=%h w=%h n=%0d e=%0b", $time,
                        rsp_bus.kind, rsp_bus.ack_number, rsp_bus.ack_checksum,
                        rsp_bus.payload_word, rsp_bus.byte_count, rsp_bus.end_of_message);
               errors++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

   typedef struct {
      logic [23:0] seq;
      logic [7:0]  len;
      bit          bad;
   } pkt_row_type;

   // directed packets: order exercised by seq, extremes of length, bad csum
   pkt_row_type dir_rows [12] = '{
      '{24'd1, 8'd120, 0}, '{24'd3, 8'd0, 0}, '{24'd2, 8'd5, 0},
      '{24'd2, 8'd9, 0},  '{24'd9, 8'd8, 0}, '{24'd4, 8'd121, 0},
      '{24'd4, 8'd255, 0}, '{24'd4, 8'd16, 1}, '{24'd0, 8'd1, 0},
      '{24'd4, 8'd64, 0}, '{24'hffffff, 8'd3, 0}, '{24'd5, 8'd7, 0}
   };

   initial begin
      int target;
      rsp_wait = 0;
      req_bus.valid = 1'b0; req_bus.command = CMD_WORD; req_bus.word_data = '0;
      predictor_reset();
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // drain with nothing pending gives nothing
      send_item(CMD_DRAIN, '1, 1, ack_of(24'd0), 0);
      for (int i = 0; i < 12; i++) begin
         send_packet(dir_rows[i].seq, dir_rows[i].len, dir_rows[i].bad);
         // words while pending are ignored
         if (pending) send_item(CMD_WORD, rand64(), 1, ack_of(24'd0), 0);
         drain_all();
      end
      wait_idle();
      target = 850;
      while (n_items < target) begin
         int r;
         logic [23:0] s;
         r = $urandom_range(0, 19);
         if (r < 13) s = 24'(in_order_seq + $urandom_range(1, WIN));
         else if (r < 15) s = 24'(in_order_seq - $urandom_range(0, 3));
         else if (r < 16) s = 24'(rand64());
         else s = 24'(in_order_seq + WIN + 1);
         if (r == 19) send_item(1'($urandom_range(0, 1)), rand64(), 0, ack_of(24'd0), 0);
         else send_packet(s, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                               : (($urandom_range(0, 5) == 0) ? 8'(ROOM)
                                                              : 8'($urandom_range(0, 40))),
                          $urandom_range(0, 9) == 0);
         if (pending && $urandom_range(0, 1)) drain_all();
         if ($urandom_range(0, 60) == 0) begin
            drain_all();
            wait_idle();
         end
      end
      drain_all();
      wait_idle();
      repeat (40) @(posedge clock);
      $display("Covered %0d request items, %0d acks and %0d payload words.",
               n_items, n_acks, n_words);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/srr_pkg.sv
hw/rtl/srr_req_if.sv
hw/rtl/srr_rsp_if.sv
hw/rtl/srr_datapath.sv
hw/rtl/srr_controller.sv
hw/rtl/selective_repeat_receiver_top.sv
tb/tb_if.sv
tb/tb.sv
